// File: rtl/nearest_scale_to_rgba5551_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the texture scaler RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SCALE_TO_RGBA5551_UNIT_MACROS_SVH
`define NEAREST_SCALE_TO_RGBA5551_UNIT_MACROS_SVH

// property checked every clock outside reset
`define NSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked in the cycle after a trigger
`define NSR_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) trig |=> prop) else $error(msg);

`endif

// File: rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Types and constants of the nearest-neighbor texture scaler.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int unsigned DIM_W   = 11;
	localparam int unsigned INDEX_W = 14;
	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned QDEPTH  = 2;

	// gradient color at the top row and its swing down to the bottom row
	localparam int unsigned GRAD_R      = 18;
	localparam int unsigned GRAD_G      = 26;
	localparam int unsigned GRAD_B      = 58;
	localparam int unsigned GRAD_R_STEP = 40;
	localparam int unsigned GRAD_G_STEP = 50;
	localparam int unsigned GRAD_B_STEP = 70;
	localparam int unsigned GRAD_SPAN   = 255;

	typedef enum logic [1:0] {
		REG_USE_SOURCE = 2'd0,
		REG_SRC_WIDTH  = 2'd1,
		REG_SRC_HEIGHT = 2'd2
	} nsr_reg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic               active;
		logic               last;
		logic [INDEX_W-1:0] index;
		logic [DIM_W-1:0]   sx;
		logic [DIM_W-1:0]   sy;
		logic [7:0]         shade;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} nsr_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} nsr_qstat_t;

endpackage

// File: rtl/nsr_fifo.sv
// ----------------------------------------------------------------------------
// nsr_fifo
// Two-entry queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
`include "nearest_scale_to_rgba5551_unit_macros.svh"

module nsr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  nsr_pkg::nsr_word_t wr_word,
	input  logic              rd_en,
	output nsr_pkg::nsr_word_t rd_word,
	output nsr_pkg::nsr_qstat_t qstat
);
	import nsr_pkg::*;

	nsr_word_t  mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_word     = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == 2'(QDEPTH));
	assign qstat.empty = (count_q == 2'd0);

	`NSR_ASSERT(a_count_bound, count_q <= 2'(QDEPTH), "queue count beyond depth")
	`NSR_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_q == $past(count_q) + 2'd1, "queue count did not rise")
	`NSR_ASSERT_NEXT(a_count_down, rd_en && !wr_en, count_q == $past(count_q) - 2'd1, "queue count did not fall")
	`NSR_ASSERT(a_ptr_gap, (wr_ptr_q == rd_ptr_q) == (count_q != 2'd1), "queue pointers out of step")

endmodule

// File: rtl/nsr_front.sv
// ----------------------------------------------------------------------------
// nsr_front
// Raster counter: tags each input pixel with its texel position and the
// nearest source coordinates of the following texel.
// ----------------------------------------------------------------------------
module nsr_front #(
	parameter int TEX_DIM = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  nsr_pkg::nsr_qstat_t          qstat,
	input  logic [7:0]                  src_red,
	input  logic [7:0]                  src_green,
	input  logic [7:0]                  src_blue,
	input  logic [7:0]                  src_alpha,
	input  logic                        src_on,
	input  logic [nsr_pkg::DIM_W-1:0]   dim_w,
	input  logic [nsr_pkg::DIM_W-1:0]   dim_h,
	output logic                        full,
	output logic                        wr_en,
	output nsr_pkg::nsr_word_t           word
);
	import nsr_pkg::*;

	localparam int CW         = (TEX_DIM > 2) ? $clog2(TEX_DIM) : 1;
	localparam int RW         = CW + 1;
	localparam int ROW_SPAN   = TEX_DIM - 1;
	localparam int SHADE_STEP = GRAD_SPAN / ROW_SPAN;
	localparam int SHADE_REM  = GRAD_SPAN % ROW_SPAN;

	logic [CW-1:0] dest_column_q;
	logic [CW-1:0] dest_row_q;
	logic [7:0]    shade_q;
	logic [CW-1:0] shade_rem_q;
	logic [CW-1:0] nx;
	logic [CW-1:0] ny;
	logic          col_end;
	logic          row_end;
	logic [RW-1:0] rem_sum;
	logic [RW-1:0] rem_diff;
	logic          rem_carry;
	logic [CW-1:0] rem_next;
	logic [7:0]    shade_next;
	logic [31:0]   index_full;
	logic [31:0]   sx_full;
	logic [31:0]   sy_full;

	assign full  = qstat.full;
	assign wr_en = push && !qstat.full;

	always_comb begin
		col_end = (dest_column_q == CW'(TEX_DIM - 1));
		row_end = (dest_row_q == CW'(TEX_DIM - 1));
		nx = col_end ? '0 : dest_column_q + 1'b1;
		if (col_end) begin
			ny = row_end ? '0 : dest_row_q + 1'b1;
		end else begin
			ny = dest_row_q;
		end
		// shade = row * span / (rows - 1), kept as quotient and remainder per row
		rem_sum    = {1'b0, shade_rem_q} + RW'(SHADE_REM);
		rem_carry  = (rem_sum >= RW'(ROW_SPAN));
		rem_diff   = rem_sum - RW'(ROW_SPAN);
		rem_next   = rem_carry ? rem_diff[CW-1:0] : rem_sum[CW-1:0];
		shade_next = shade_q + 8'(SHADE_STEP) + {7'd0, rem_carry};
		index_full = 32'(dest_row_q) * 32'(TEX_DIM) + 32'(dest_column_q);
		sx_full    = (32'(nx) * 32'(dim_w)) / TEX_DIM;
		sy_full    = (32'(ny) * 32'(dim_h)) / TEX_DIM;
	end

	always_comb begin
		word.active = src_on;
		word.last   = col_end && row_end;
		word.index  = index_full[INDEX_W-1:0];
		word.sx     = sx_full[DIM_W-1:0];
		word.sy     = sy_full[DIM_W-1:0];
		word.shade  = shade_q;
		word.red    = src_red;
		word.green  = src_green;
		word.blue   = src_blue;
		word.alpha  = src_alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_column_q <= '0;
			dest_row_q    <= '0;
			shade_q       <= '0;
			shade_rem_q   <= '0;
		end else if (wr_en) begin
			dest_column_q <= nx;
			dest_row_q    <= ny;
			if (col_end) begin
				if (row_end) begin
					shade_q     <= '0;
					shade_rem_q <= '0;
				end else begin
					shade_q     <= shade_next;
					shade_rem_q <= rem_next;
				end
			end
		end
	end

endmodule

// File: rtl/nsr_back.sv
// ----------------------------------------------------------------------------
// nsr_back
// Texel packing and fetch address: converts the queued word and holds the
// result word until it is popped.
// ----------------------------------------------------------------------------
module nsr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsr_pkg::nsr_qstat_t            qstat,
	input  nsr_pkg::nsr_word_t             word,
	input  logic [nsr_pkg::DIM_W-1:0]     dim_w,
	input  logic                          pop,
	output logic                          rd_en,
	output logic                          empty,
	output logic [15:0]                   texel,
	output logic [nsr_pkg::INDEX_W-1:0]   texel_index,
	output logic [nsr_pkg::ADDR_W-1:0]    next_fetch_address,
	output logic                          last_texel
);
	import nsr_pkg::*;

	logic        out_valid_q;
	logic [31:0] grad_r;
	logic [31:0] grad_g;
	logic [31:0] grad_b;
	logic [31:0] addr_full;
	logic [15:0] texel_d;

	// x / 255 by reciprocal; exact for the gradient products (below 2^15)
	function automatic logic [7:0] div_span(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	assign rd_en = !qstat.empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	always_comb begin
		grad_r = 32'(GRAD_R) + 32'(div_span(16'(word.shade) * 16'(GRAD_R_STEP)));
		grad_g = 32'(GRAD_G) + 32'(div_span(16'(word.shade) * 16'(GRAD_G_STEP)));
		grad_b = 32'(GRAD_B) + 32'(div_span(16'(word.shade) * 16'(GRAD_B_STEP)));
		addr_full = 32'(word.sy) * 32'(dim_w) + 32'(word.sx);
		if (!word.active) begin
			texel_d = {1'b1, grad_b[7:3], grad_g[7:3], grad_r[7:3]};
		end else if (!word.alpha[7]) begin
			texel_d = '0;
		end else begin
			texel_d = {1'b1, word.blue[7:3], word.green[7:3], word.red[7:3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_en) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			texel              <= texel_d;
			texel_index        <= word.index;
			next_fetch_address <= word.active ? addr_full[ADDR_W-1:0] : '0;
			last_texel         <= word.last;
		end
	end

endmodule

// File: rtl/nearest_scale_to_rgba5551_unit.sv
// ----------------------------------------------------------------------------
// nearest_scale_to_rgba5551_unit
// Nearest-neighbor scaler to a square A1B5G5R5 texture, with a blue
// gradient when no source image is set.
//
//   channel   handshake          payload
//   input     push / full        src_red, src_green, src_blue, src_alpha
//   result    empty / pop        texel, texel_index, next_fetch_address, last_texel
//   config    cfg_valid / ready  cfg_index, cfg_data
//
// One word per cycle sustained while pop keeps up; a pushed word reaches the
// result ports through the queue (written by the front) and then the back register.
// The two-entry queue and the result register absorb stalls; full rises only
// when both queue entries wait behind an untaken result.
// Reset clears the raster position, the queue and the registers; no sweep.
// ----------------------------------------------------------------------------
module nearest_scale_to_rgba5551_unit #(
	parameter int TEX_DIM     = 128,
	parameter int MAX_SRC_DIM = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   src_red,
	input  logic [7:0]                   src_green,
	input  logic [7:0]                   src_blue,
	input  logic [7:0]                   src_alpha,
	output logic                         empty,
	input  logic                         pop,
	output logic [15:0]                  texel,
	output logic [nsr_pkg::INDEX_W-1:0]  texel_index,
	output logic [nsr_pkg::ADDR_W-1:0]   next_fetch_address,
	output logic                         last_texel,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [nsr_pkg::DIM_W-1:0]    cfg_data
);
	import nsr_pkg::*;

	logic               use_source_q;
	logic [DIM_W-1:0]   src_width_q;
	logic [DIM_W-1:0]   src_height_q;
	logic [DIM_W-1:0]   dim_w;
	logic [DIM_W-1:0]   dim_h;
	logic               src_on;
	logic               wr_en;
	logic               rd_en;
	nsr_word_t          wr_word;
	nsr_word_t          rd_word;
	nsr_qstat_t         qstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_source_q <= 1'b0;
			src_width_q  <= '0;
			src_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_USE_SOURCE: use_source_q <= cfg_data[0];
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sizes above the supported maximum act as the maximum
	always_comb begin
		dim_w  = (32'(src_width_q) > 32'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_width_q;
		dim_h  = (32'(src_height_q) > 32'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_height_q;
		src_on = use_source_q && (dim_w != '0) && (dim_h != '0);
	end

	nsr_front #(
		.TEX_DIM (TEX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.qstat     (qstat),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.src_alpha (src_alpha),
		.src_on    (src_on),
		.dim_w     (dim_w),
		.dim_h     (dim_h),
		.full      (full),
		.wr_en     (wr_en),
		.word      (wr_word)
	);

	nsr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_word (wr_word),
		.rd_en   (rd_en),
		.rd_word (rd_word),
		.qstat   (qstat)
	);

	nsr_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.qstat              (qstat),
		.word               (rd_word),
		.dim_w              (dim_w),
		.pop                (pop),
		.rd_en              (rd_en),
		.empty              (empty),
		.texel              (texel),
		.texel_index        (texel_index),
		.next_fetch_address (next_fetch_address),
		.last_texel         (last_texel)
	);

endmodule

// File: bench/nearest_scale_to_rgba5551_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_scale_to_rgba5551_unit_test
// Self-checking bench for the texture scaler. A short scripted run covers the
// reset gradient, disabled and oversized sources, the alpha threshold and the
// channel packing. Then short phases of random settings and pixels follow,
// one of them with the consumer held off until the input stalls.
// Every word popped is checked field by field against an in-bench texel model.
// ----------------------------------------------------------------------------
module nearest_scale_to_rgba5551_unit_test;

	import nsr_pkg::*;

	localparam int unsigned TEX_DIM      = 128;
	localparam int unsigned MAX_SRC_DIM  = 1024;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam logic [1:0]  REG_NONE     = 2'd3;

	typedef struct packed {
		logic [15:0]       texel;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0] fetch;
		logic              last;
	} texel_word_t;

	typedef struct packed {
		logic             wr;
		logic [1:0]       idx;
		logic [DIM_W-1:0] val;
		logic [31:0]      pixel;   // red, green, blue, alpha
		logic             typed;
		logic [15:0]      texel;
	} script_row_t;

	localparam int unsigned SCRIPT_ROWS = 24;

	// word rows with typed = 1 carry the texel that is known at a glance
	script_row_t script [SCRIPT_ROWS] = '{
		'{1'b0, REG_NONE,       11'd0,    32'hFFFFFFFF, 1'b1, 16'h9C62},
		'{1'b0, REG_NONE,       11'd0,    32'h00000000, 1'b1, 16'h9C62},
		'{1'b1, REG_USE_SOURCE, 11'h001,  32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'hFFFFFFFF, 1'b1, 16'h9C62},
		'{1'b1, REG_SRC_WIDTH,  11'd1024, 32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'hFFFFFFFF, 1'b1, 16'h9C62},
		'{1'b1, REG_SRC_HEIGHT, 11'd2047, 32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'hFFFFFF80, 1'b1, 16'hFFFF},
		'{1'b0, REG_NONE,       11'd0,    32'hFFFFFF7F, 1'b1, 16'h0000},
		'{1'b0, REG_NONE,       11'd0,    32'h000000FF, 1'b1, 16'h8000},
		'{1'b0, REG_NONE,       11'd0,    32'hF80707FF, 1'b1, 16'h801F},
		'{1'b0, REG_NONE,       11'd0,    32'h07F807FF, 1'b1, 16'h83E0},
		'{1'b0, REG_NONE,       11'd0,    32'h0707F880, 1'b1, 16'hFC00},
		'{1'b1, REG_NONE,       11'h7FF,  32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'h5AA53CC3, 1'b0, 16'h0},
		'{1'b1, REG_USE_SOURCE, 11'h7FE,  32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'h123456FF, 1'b1, 16'h9C62},
		'{1'b1, REG_USE_SOURCE, 11'h003,  32'h0,        1'b0, 16'h0},
		'{1'b1, REG_SRC_WIDTH,  11'd1,    32'h0,        1'b0, 16'h0},
		'{1'b1, REG_SRC_HEIGHT, 11'd1,    32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'h80808000, 1'b1, 16'h0000},
		'{1'b0, REG_NONE,       11'd0,    32'h817E00FE, 1'b0, 16'h0},
		'{1'b1, REG_SRC_WIDTH,  11'd1500, 32'h0,        1'b0, 16'h0},
		'{1'b0, REG_NONE,       11'd0,    32'h6B00FF80, 1'b0, 16'h0}
	};

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         src_red;
	logic [7:0]         src_green;
	logic [7:0]         src_blue;
	logic [7:0]         src_alpha;
	logic               empty;
	logic               pop;
	logic [15:0]        texel;
	logic [INDEX_W-1:0] texel_index;
	logic [ADDR_W-1:0]  next_fetch_address;
	logic               last_texel;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [DIM_W-1:0]   cfg_data;

	// texel model state
	logic             use_src;
	logic [DIM_W-1:0] src_w;
	logic [DIM_W-1:0] src_h;
	logic [6:0]       raster_col;
	logic [6:0]       raster_row;

	texel_word_t pending_texels [$];
	int unsigned mismatch_count;
	int unsigned hold_requests;
	int unsigned cycle_count;
	bit          quiet;

	nearest_scale_to_rgba5551_unit #(
		.TEX_DIM(TEX_DIM),
		.MAX_SRC_DIM(MAX_SRC_DIM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.src_red(src_red),
		.src_green(src_green),
		.src_blue(src_blue),
		.src_alpha(src_alpha),
		.empty(empty),
		.pop(pop),
		.texel(texel),
		.texel_index(texel_index),
		.next_fetch_address(next_fetch_address),
		.last_texel(last_texel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return 11'd1;
			2: return 11'(MAX_SRC_DIM);
			3: return 11'($urandom_range(2047, MAX_SRC_DIM + 1));
			4: return 11'd2047;
			default: return 11'($urandom_range(MAX_SRC_DIM, 1));
		endcase
	endfunction

	function automatic logic [31:0] random_pixel();
		logic [31:0] pix;
		pix = $urandom;
		case ($urandom_range(7))
			0: pix[7:0] = 8'd127;
			1: pix[7:0] = 8'd128;
			2: pix[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return pix;
	endfunction

	// texel for the current raster position; advances the position
	task automatic forecast_texel(input logic [31:0] pix, output texel_word_t due);
		int unsigned w, h, shade, rd, gr, bl, nx, ny;
		bit live;
		w = (src_w > MAX_SRC_DIM) ? MAX_SRC_DIM : src_w;
		h = (src_h > MAX_SRC_DIM) ? MAX_SRC_DIM : src_h;
		live = use_src && w != 0 && h != 0;
		if (live) begin
			if (pix[7:0] < 8'd128)
				due.texel = '0;
			else
				due.texel = {1'b1, pix[15:11], pix[23:19], pix[31:27]};
		end else begin
			shade = raster_row * GRAD_SPAN / (TEX_DIM - 1);
			rd = GRAD_R + shade * GRAD_R_STEP / GRAD_SPAN;
			gr = GRAD_G + shade * GRAD_G_STEP / GRAD_SPAN;
			bl = GRAD_B + shade * GRAD_B_STEP / GRAD_SPAN;
			due.texel = {1'b1, 5'(bl >> 3), 5'(gr >> 3), 5'(rd >> 3)};
		end
		due.index = INDEX_W'(raster_row * TEX_DIM + raster_col);
		due.last = raster_col == TEX_DIM - 1 && raster_row == TEX_DIM - 1;
		nx = raster_col + 1;
		ny = raster_row;
		if (nx >= TEX_DIM) begin
			nx = 0;
			ny = (raster_row + 1 >= TEX_DIM) ? 0 : raster_row + 1;
		end
		due.fetch = live ? ADDR_W'((ny * h / TEX_DIM) * w + nx * w / TEX_DIM) : '0;
		raster_col = 7'(nx);
		raster_row = 7'(ny);
	endtask

	task automatic send_word(input logic [31:0] pix, input bit typed, input logic [15:0] fixed);
		int unsigned gap;
		texel_word_t due;
		gap = pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		{src_red, src_green, src_blue, src_alpha} <= pix;
		@(posedge clk);
		while (full) @(posedge clk);
		forecast_texel(pix, due);
		if (typed)
			due.texel = fixed;
		pending_texels.push_back(due);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_texels.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_USE_SOURCE: use_src = val[0];
			REG_SRC_WIDTH:  src_w = val;
			REG_SRC_HEIGHT: src_h = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input bit force_live);
		logic [DIM_W-1:0] vals [4];
		nsr_reg_t order [3];
		int unsigned first;
		int unsigned k;
		wait_idle();
		vals[REG_USE_SOURCE] = 11'($urandom);
		vals[REG_USE_SOURCE][0] = force_live || $urandom_range(99) < 80;
		vals[REG_SRC_WIDTH] = pick_dim();
		vals[REG_SRC_HEIGHT] = pick_dim();
		while (force_live && vals[REG_SRC_WIDTH] == 0) vals[REG_SRC_WIDTH] = pick_dim();
		while (force_live && vals[REG_SRC_HEIGHT] == 0) vals[REG_SRC_HEIGHT] = pick_dim();
		order[0] = REG_USE_SOURCE;
		order[1] = REG_SRC_WIDTH;
		order[2] = REG_SRC_HEIGHT;
		if ($urandom_range(3) == 0)
			write_reg(REG_NONE, 11'($urandom));
		first = $urandom_range(2);
		for (k = 0; k < 3; k++)
			write_reg(order[(first + k) % 3], vals[order[(first + k) % 3]]);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned i, j, n, random_items, phase;
		bit writing;
		arst_n <= 1'b0;
		push <= 1'b0;
		src_red <= '0;
		src_green <= '0;
		src_blue <= '0;
		src_alpha <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_NONE;
		cfg_data <= '0;
		quiet = 1'b0;
		hold_requests = 0;
		mismatch_count = 0;
		use_src = 1'b0;
		src_w = '0;
		src_h = '0;
		raster_col = '0;
		raster_row = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		writing = 1'b0;
		for (i = 0; i < SCRIPT_ROWS; i++) begin
			if (script[i].wr) begin
				if (!writing)
					wait_idle();
				write_reg(script[i].idx, script[i].val);
				writing = 1'b1;
			end else begin
				if (writing) begin
					cfg_valid <= 1'b0;
					writing = 1'b0;
				end
				send_word(script[i].pixel, script[i].typed, script[i].texel);
			end
		end

		// the first random phase always samples a source
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			quiet = $urandom_range(99) < 25;
			set_config(phase == 0);
			n = ($urandom_range(99) < 80) ? $urandom_range(60, 10) : $urandom_range(200, 100);
			if (phase == 2) begin
				// consumer stalls while words keep coming, so full must rise
				quiet = 1'b1;
				hold_requests++;
				n = 40;
			end
			for (j = 0; j < n; j++)
				send_word(random_pixel(), 1'b0, '0);
			random_items += n;
			phase++;
		end

		quiet = 1'b1;
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[nearest_scale_to_rgba5551_unit] OK");
		else
			$display("[nearest_scale_to_rgba5551_unit] ERROR");
		$finish;
	end

	initial begin : consumer
		int unsigned stall, hold_left, holds_seen;
		texel_word_t due, got;
		pop <= 1'b0;
		stall = 0;
		hold_left = 0;
		holds_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = '{texel, texel_index, next_fetch_address, last_texel};
				if (pending_texels.size() == 0) begin
					$display("%0t: unexpected word texel %h index %0d", $time, texel, texel_index);
					mismatch_count++;
				end else begin
					due = pending_texels.pop_front();
					if (got.texel !== due.texel) begin
						$display("%0t: texel expected %h got %h", $time, due.texel, got.texel);
						mismatch_count++;
					end
					if (got.index !== due.index) begin
						$display("%0t: texel_index expected %0d got %0d",
							$time, due.index, got.index);
						mismatch_count++;
					end
					if (got.fetch !== due.fetch) begin
						$display("%0t: next_fetch_address expected %0d got %0d",
							$time, due.fetch, got.fetch);
						mismatch_count++;
					end
					if (got.last !== due.last) begin
						$display("%0t: last_texel expected %b got %b", $time, due.last, got.last);
						mismatch_count++;
					end
				end
			end
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (quiet) begin
				stall = 0;
				pop <= 1'b1;
			end else begin
				if (stall == 0)
					stall = pick_gap();
				if (stall != 0) begin
					stall--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[nearest_scale_to_rgba5551_unit] ERROR");
		$finish;
	end

endmodule

// File: nearest_scale_to_rgba5551_unit.f
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_fifo.sv
rtl/nsr_front.sv
rtl/nsr_back.sv
rtl/nearest_scale_to_rgba5551_unit.sv
bench/nearest_scale_to_rgba5551_unit_test.sv
